### src/adam_parameter_update_core_macros.svh
// Assertion macros shared by the Adam update core RTL.
`ifndef ADAM_PARAMETER_UPDATE_CORE_MACROS_SVH
`define ADAM_PARAMETER_UPDATE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Invariant checked at every edge out of reset.
`define APU_ASSERT_ALW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Same-cycle implication.
`define APU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define APU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APU_ASSERT_ALW(lbl, clk, rst_n, expr, msg)
`define APU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define APU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/apu_pkg.sv
// Constants, types and helper functions of the Adam update core.
`default_nettype none
package apu_pkg;
    localparam int FRAC_BITS = 28;
    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF_LSB = 64'd1 << (FRAC_BITS - 1);
    localparam longint HALF_S = longint'(HALF_LSB);
    localparam longint unsigned B1 = (64'd9 * ONE + 64'd5) / 64'd10;
    localparam longint unsigned B2 = (64'd999 * ONE + 64'd500) / 64'd1000;
    localparam longint unsigned EPS = (ONE + 64'd50000000) / 64'd100000000;
    localparam logic signed [31:0] B1_S = 32'(B1);
    localparam logic signed [31:0] OMB1_S = 32'(ONE - B1);
    localparam int CORR_FRAC = 20 + (FRAC_BITS % 2);
    localparam int ROOT_FRAC = (FRAC_BITS + CORR_FRAC) / 2;
    localparam int SH_R = (ROOT_FRAC >= FRAC_BITS) ? ROOT_FRAC - FRAC_BITS : 0;
    localparam int SH_L = (ROOT_FRAC >= FRAC_BITS) ? 0 : FRAC_BITS - ROOT_FRAC;

    // correction engine
    localparam int PW_W = FRAC_BITS + 1;
    localparam int CDIV_W = FRAC_BITS + CORR_FRAC + 1;
    localparam int CCNT_W = $clog2(CDIV_W);
    localparam longint unsigned CNUM = 64'd1 << (FRAC_BITS + CORR_FRAC);
    localparam longint unsigned C1_FULL = (CNUM + (ONE - B1) / 64'd2) / (ONE - B1);
    localparam longint unsigned C2_FULL = (CNUM + (ONE - B2) / 64'd2) / (ONE - B2);
    localparam logic [31:0] C1_RST = (C1_FULL > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(C1_FULL);
    localparam logic [31:0] C2_RST = (C2_FULL > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(C2_FULL);

    // datapath widths
    localparam int LR_W = 31;
    localparam int G2_W = 64 - FRAC_BITS;
    localparam int MH_W = 64 - CORR_FRAC;
    localparam int MH_LO_W = MH_W / 2;
    localparam int MH_HI_W = MH_W - MH_LO_W;
    localparam int PLO_W = LR_W + MH_LO_W;
    localparam int PHI_W = LR_W + MH_HI_W;
    localparam int NUM_W = LR_W + MH_W;
    localparam int DIVN_W = NUM_W + (NUM_W % 2);
    localparam int DIV_STG = DIVN_W / 2;
    localparam int SQ_STG = 16;
    localparam int D_W = 41;
    localparam int UPD_W = 41;
    localparam logic [UPD_W-1:0] UPD_CAP = UPD_W'(64'd1 << 40);

    typedef struct packed {
        logic signed [31:0] p;
        logic signed [31:0] m_new;
        logic [30:0]        v_new;
        logic               sat;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_param;
        logic signed [31:0] new_first_moment;
        logic [30:0]        new_second_moment;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [D_W-1:0]    r;
        logic [DIVN_W-1:0] nq;
    } div_t;

    function automatic logic [PW_W-1:0] mul_q(input logic [PW_W-1:0] a,
                                              input logic [PW_W-1:0] b);
        logic [2*PW_W-1:0] pr;
        pr = (2*PW_W)'(a) * (2*PW_W)'(b) + (2*PW_W)'(HALF_LSB);
        return PW_W'(pr >> FRAC_BITS);
    endfunction

    function automatic logic [63:0] sq_bit(input int j);
        return 64'd1 << (62 - 2 * j);
    endfunction

    function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] b);
        sqrt_t o;
        logic [63:0] t;
        t = s.res + b;
        if (s.rem >= t)
        begin
            o.rem = s.rem - t;
            o.res = (s.res >> 1) + b;
        end
        else
        begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // one restoring step: dividend bits shift out of nq, quotient bits in
    function automatic div_t div_step(input div_t s, input logic [D_W-1:0] d);
        div_t o;
        logic [D_W:0] r2;
        r2 = {s.r, s.nq[DIVN_W-1]};
        if (r2 >= {1'b0, d})
        begin
            o.r  = D_W'(r2 - {1'b0, d});
            o.nq = {s.nq[DIVN_W-2:0], 1'b1};
        end
        else
        begin
            o.r  = D_W'(r2);
            o.nq = {s.nq[DIVN_W-2:0], 1'b0};
        end
        return o;
    endfunction
endpackage
`default_nettype wire

### src/apu_corr.sv
// Bias correction engine: square-and-multiply power, then serial divide.
`default_nettype none
module apu_corr (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] step,
    output logic        busy,
    output logic [31:0] c1,
    output logic [31:0] c2
);
    import apu_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_SQ, ST_ML, ST_DP, ST_DV, ST_FIN} state_t;

    state_t             state_reg;
    logic [15:0]        t_reg;
    logic [3:0]         bit_reg;
    logic [CCNT_W-1:0]  dcnt_reg;
    logic [PW_W-1:0]    pw1_reg, pw2_reg, dn1_reg, dn2_reg, r1_reg, r2_reg;
    logic [CDIV_W-1:0]  nq1_reg, nq2_reg;
    logic               z1_reg, z2_reg;
    logic [31:0]        c1_reg, c2_reg;

    logic [PW_W-1:0]    mul1_w, mul2_w, den1_w, den2_w, r1_next, r2_next;
    logic [CDIV_W-1:0]  nq1_next, nq2_next;
    logic [PW_W:0]      sh1_w, sh2_w;
    logic               ge1_w, ge2_w;

    always_comb
    begin
        mul1_w = mul_q(pw1_reg, (state_reg == ST_SQ) ? pw1_reg : PW_W'(B1));
        mul2_w = mul_q(pw2_reg, (state_reg == ST_SQ) ? pw2_reg : PW_W'(B2));
        den1_w = PW_W'(ONE) - pw1_reg;
        den2_w = PW_W'(ONE) - pw2_reg;
        sh1_w  = {r1_reg, nq1_reg[CDIV_W-1]};
        sh2_w  = {r2_reg, nq2_reg[CDIV_W-1]};
        ge1_w  = sh1_w >= {1'b0, dn1_reg};
        ge2_w  = sh2_w >= {1'b0, dn2_reg};
        r1_next = ge1_w ? PW_W'(sh1_w - {1'b0, dn1_reg}) : PW_W'(sh1_w);
        r2_next = ge2_w ? PW_W'(sh2_w - {1'b0, dn2_reg}) : PW_W'(sh2_w);
        nq1_next = {nq1_reg[CDIV_W-2:0], ge1_w};
        nq2_next = {nq2_reg[CDIV_W-2:0], ge2_w};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            bit_reg   <= '0;
            dcnt_reg  <= '0;
            pw1_reg   <= '0;
            pw2_reg   <= '0;
            dn1_reg   <= '0;
            dn2_reg   <= '0;
            r1_reg    <= '0;
            r2_reg    <= '0;
            nq1_reg   <= '0;
            nq2_reg   <= '0;
            z1_reg    <= 1'b0;
            z2_reg    <= 1'b0;
            c1_reg    <= C1_RST;
            c2_reg    <= C2_RST;
        end
        else if (start)
        begin
            // a new step value restarts the engine from any state
            t_reg     <= step;
            pw1_reg   <= PW_W'(ONE);
            pw2_reg   <= PW_W'(ONE);
            bit_reg   <= 4'd15;
            state_reg <= ST_SQ;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    ;
                ST_SQ:
                begin
                    pw1_reg   <= mul1_w;
                    pw2_reg   <= mul2_w;
                    state_reg <= ST_ML;
                end
                ST_ML:
                begin
                    if (t_reg[bit_reg])
                    begin
                        pw1_reg <= mul1_w;
                        pw2_reg <= mul2_w;
                    end
                    if (bit_reg == 4'd0)
                        state_reg <= ST_DP;
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_DP:
                begin
                    dn1_reg   <= den1_w;
                    dn2_reg   <= den2_w;
                    z1_reg    <= (den1_w == '0);
                    z2_reg    <= (den2_w == '0);
                    nq1_reg   <= CDIV_W'(CNUM) + CDIV_W'(den1_w >> 1);
                    nq2_reg   <= CDIV_W'(CNUM) + CDIV_W'(den2_w >> 1);
                    r1_reg    <= '0;
                    r2_reg    <= '0;
                    dcnt_reg  <= CCNT_W'(CDIV_W - 1);
                    state_reg <= ST_DV;
                end
                ST_DV:
                begin
                    r1_reg  <= r1_next;
                    r2_reg  <= r2_next;
                    nq1_reg <= nq1_next;
                    nq2_reg <= nq2_next;
                    if (dcnt_reg == '0)
                        state_reg <= ST_FIN;
                    else
                        dcnt_reg <= dcnt_reg - 1'b1;
                end
                ST_FIN:
                begin
                    // zero denominator or oversize quotient saturates
                    c1_reg <= (z1_reg || (|nq1_reg[CDIV_W-1:32])) ? 32'hFFFFFFFF
                                                                  : nq1_reg[31:0];
                    c2_reg <= (z2_reg || (|nq2_reg[CDIV_W-1:32])) ? 32'hFFFFFFFF
                                                                  : nq2_reg[31:0];
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign c1   = c1_reg;
    assign c2   = c2_reg;
endmodule
`default_nettype wire

### src/apu_front.sv
// Front pipeline: moment updates, bias-corrected mean, numerator and root operand.
`default_nettype none
module apu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        up_valid,
    input  logic signed [31:0]          param_value,
    input  logic signed [31:0]          first_moment,
    input  logic [30:0]                 second_moment,
    input  logic signed [31:0]          gradient,
    input  logic [apu_pkg::LR_W-1:0]    lr,
    input  logic [31:0]                 c1,
    input  logic [31:0]                 c2,
    output logic                        dn_valid,
    output apu_pkg::item_t              dn_item,
    output logic [63:0]                 dn_x,
    output logic [apu_pkg::NUM_W-1:0]   dn_num
);
    import apu_pkg::*;

    logic [4:0] vld_reg;

    // stage 1
    logic signed [31:0] f1_p_reg;
    logic signed [63:0] f1_pm1_reg, f1_pm2_reg;
    logic [63:0]        f1_gsq_reg;
    logic [30:0]        f1_v_reg;
    // stage 2
    logic signed [31:0] f2_p_reg, f2_m_reg;
    logic               f2_sat_reg;
    logic [G2_W-1:0]    f2_g2_reg;
    logic [30:0]        f2_v_reg;
    // stage 3
    logic signed [31:0] f3_p_reg, f3_m_reg;
    logic               f3_sat_reg;
    logic [63:0]        f3_pv1_reg, f3_pv2_reg, f3_pmc_reg;
    // stage 4
    logic signed [31:0] f4_p_reg, f4_m_reg;
    logic               f4_sat_reg;
    logic [30:0]        f4_v_reg;
    logic [PLO_W-1:0]   f4_plo_reg;
    logic [PHI_W-1:0]   f4_phi_reg;
    // stage 5
    item_t              f5_item_reg;
    logic [63:0]        f5_x_reg;
    logic [NUM_W-1:0]   f5_num_reg;

    logic [31:0]        gmag_w, mmag_w;
    logic signed [63:0] pm1_w, pm2_w, msum_w, mrnd_w;
    logic [63:0]        gsq_w, g2_w, vrnd_w;
    logic               mhi_w, mlo_w, vsat_w;
    logic [MH_W-1:0]    mhat_w;

    always_comb
    begin
        pm1_w  = 64'(B1_S) * 64'(first_moment);
        pm2_w  = 64'(OMB1_S) * 64'(gradient);
        gmag_w = gradient[31] ? 32'(-gradient) : 32'(gradient);
        gsq_w  = 64'(gmag_w) * 64'(gmag_w);

        msum_w = f1_pm1_reg + f1_pm2_reg + HALF_S;
        mrnd_w = msum_w >>> FRAC_BITS;
        mhi_w  = mrnd_w > 64'sd2147483647;
        mlo_w  = mrnd_w < -64'sd2147483648;
        g2_w   = (f1_gsq_reg + HALF_LSB) >> FRAC_BITS;

        mmag_w = f2_m_reg[31] ? 32'(-f2_m_reg) : 32'(f2_m_reg);

        vrnd_w = (f3_pv1_reg + f3_pv2_reg + HALF_LSB) >> FRAC_BITS;
        vsat_w = vrnd_w > 64'h7FFFFFFF;
        mhat_w = MH_W'(f3_pmc_reg >> CORR_FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], up_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_p_reg   <= param_value;
            f1_pm1_reg <= pm1_w;
            f1_pm2_reg <= pm2_w;
            f1_gsq_reg <= gsq_w;
            f1_v_reg   <= second_moment;

            f2_p_reg   <= f1_p_reg;
            f2_m_reg   <= mhi_w ? 32'sh7FFFFFFF : (mlo_w ? 32'sh80000000 : 32'(mrnd_w));
            f2_sat_reg <= mhi_w | mlo_w;
            f2_g2_reg  <= G2_W'(g2_w);
            f2_v_reg   <= f1_v_reg;

            f3_p_reg   <= f2_p_reg;
            f3_m_reg   <= f2_m_reg;
            f3_sat_reg <= f2_sat_reg;
            f3_pv1_reg <= 64'(B2) * 64'(f2_v_reg);
            f3_pv2_reg <= 64'(ONE - B2) * 64'(f2_g2_reg);
            f3_pmc_reg <= 64'(mmag_w) * 64'(c1);

            f4_p_reg   <= f3_p_reg;
            f4_m_reg   <= f3_m_reg;
            f4_sat_reg <= f3_sat_reg | vsat_w;
            f4_v_reg   <= vsat_w ? 31'h7FFFFFFF : vrnd_w[30:0];
            f4_plo_reg <= PLO_W'(lr) * PLO_W'(mhat_w[MH_LO_W-1:0]);
            f4_phi_reg <= PHI_W'(lr) * PHI_W'(mhat_w[MH_W-1:MH_LO_W]);

            f5_item_reg.p     <= f4_p_reg;
            f5_item_reg.m_new <= f4_m_reg;
            f5_item_reg.v_new <= f4_v_reg;
            f5_item_reg.sat   <= f4_sat_reg;
            f5_x_reg   <= 64'(f4_v_reg) * 64'(c2);
            f5_num_reg <= NUM_W'(f4_plo_reg) + (NUM_W'(f4_phi_reg) << MH_LO_W);
        end
    end

    assign dn_valid = vld_reg[4];
    assign dn_item  = f5_item_reg;
    assign dn_x     = f5_x_reg;
    assign dn_num   = f5_num_reg;
endmodule
`default_nettype wire

### src/apu_sqrt.sv
// Pipelined integer square root, two bits of root per stage.
`default_nettype none
module apu_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        up_valid,
    input  apu_pkg::item_t              up_item,
    input  logic [63:0]                 up_x,
    input  logic [apu_pkg::NUM_W-1:0]   up_num,
    output logic                        dn_valid,
    output apu_pkg::item_t              dn_item,
    output logic [apu_pkg::NUM_W-1:0]   dn_num,
    output logic [31:0]                 dn_root
);
    import apu_pkg::*;

    logic [SQ_STG-1:0] vld_reg;
    sqrt_t             st_reg   [SQ_STG];
    item_t             item_reg [SQ_STG];
    logic [NUM_W-1:0]  num_reg  [SQ_STG];
    sqrt_t             src_w    [SQ_STG];
    sqrt_t             nxt_w    [SQ_STG];

    always_comb
    begin
        src_w[0].rem = up_x;
        src_w[0].res = '0;
        for (int s = 1; s < SQ_STG; s++)
            src_w[s] = st_reg[s-1];
        for (int s = 0; s < SQ_STG; s++)
            nxt_w[s] = sqrt_step(sqrt_step(src_w[s], sq_bit(2 * s)), sq_bit(2 * s + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[SQ_STG-2:0], up_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg      <= nxt_w;
            item_reg[0] <= up_item;
            num_reg[0]  <= up_num;
            for (int s = 1; s < SQ_STG; s++)
            begin
                item_reg[s] <= item_reg[s-1];
                num_reg[s]  <= num_reg[s-1];
            end
        end
    end

    assign dn_valid = vld_reg[SQ_STG-1];
    assign dn_item  = item_reg[SQ_STG-1];
    assign dn_num   = num_reg[SQ_STG-1];
    assign dn_root  = st_reg[SQ_STG-1].res[31:0];
endmodule
`default_nettype wire

### src/apu_div.sv
// Denominator build, pipelined restoring divider and parameter write-back.
`default_nettype none
module apu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        up_valid,
    input  apu_pkg::item_t              up_item,
    input  logic [apu_pkg::NUM_W-1:0]   up_num,
    input  logic [31:0]                 up_root,
    output logic                        dn_valid,
    output apu_pkg::result_t            dn_res
);
    import apu_pkg::*;

    logic               pre_vld_reg;
    logic [D_W-1:0]     pre_d_reg;
    item_t              pre_item_reg;
    logic [DIVN_W-1:0]  pre_n_reg;

    logic [DIV_STG-1:0] vld_reg;
    div_t               dv_reg   [DIV_STG];
    logic [D_W-1:0]     d_reg    [DIV_STG];
    item_t              item_reg [DIV_STG];
    div_t               src_w    [DIV_STG];
    div_t               nxt_w    [DIV_STG];
    logic [D_W-1:0]     dsrc_w   [DIV_STG];

    logic               res_vld_reg;
    result_t            res_reg;

    logic [D_W-1:0]     den_w;
    logic [UPD_W-1:0]   upd_w;
    logic signed [43:0] pe_w, ue_w, pn_w;
    logic               phi_w, plo_w;
    item_t              last_w;

    always_comb
    begin
        den_w = ((D_W'(up_root) >> SH_R) << SH_L) + D_W'(EPS);
        if (den_w == '0)
            den_w = D_W'(1);

        src_w[0].r  = '0;
        src_w[0].nq = pre_n_reg;
        dsrc_w[0]   = pre_d_reg;
        for (int s = 1; s < DIV_STG; s++)
        begin
            src_w[s]  = dv_reg[s-1];
            dsrc_w[s] = d_reg[s-1];
        end
        for (int s = 0; s < DIV_STG; s++)
            nxt_w[s] = div_step(div_step(src_w[s], dsrc_w[s]), dsrc_w[s]);

        // quotient capped before it is applied
        upd_w = (dv_reg[DIV_STG-1].nq > DIVN_W'(UPD_CAP)) ? UPD_CAP
                                                           : UPD_W'(dv_reg[DIV_STG-1].nq);
        last_w = item_reg[DIV_STG-1];
        pe_w   = 44'(last_w.p);
        ue_w   = signed'(44'(upd_w));
        pn_w   = last_w.m_new[31] ? pe_w + ue_w : pe_w - ue_w;
        phi_w  = pn_w > 44'sd2147483647;
        plo_w  = pn_w < -44'sd2147483648;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_vld_reg <= up_valid;
            vld_reg     <= {vld_reg[DIV_STG-2:0], pre_vld_reg};
            res_vld_reg <= vld_reg[DIV_STG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_d_reg    <= den_w;
            pre_item_reg <= up_item;
            pre_n_reg    <= DIVN_W'(up_num);
            dv_reg       <= nxt_w;
            d_reg[0]     <= pre_d_reg;
            item_reg[0]  <= pre_item_reg;
            for (int s = 1; s < DIV_STG; s++)
            begin
                d_reg[s]    <= d_reg[s-1];
                item_reg[s] <= item_reg[s-1];
            end
            res_reg.new_param         <= phi_w ? 32'sh7FFFFFFF
                                       : (plo_w ? 32'sh80000000 : 32'(pn_w));
            res_reg.new_first_moment  <= last_w.m_new;
            res_reg.new_second_moment <= last_w.v_new;
            res_reg.saturated         <= last_w.sat | phi_w | plo_w;
        end
    end

    assign dn_valid = res_vld_reg;
    assign dn_res   = res_reg;
endmodule
`default_nettype wire

### src/adam_parameter_update_core.sv
// Top level of the Adam parameter update core: register port, pipeline, output queue.
`default_nettype none
`include "adam_parameter_update_core_macros.svh"
//
//  Channel   Direction  Handshake              Contents
//  --------  ---------  ---------------------  ------------------------------------------
//  in        sink       in_valid / in_stall    param_value, first_moment, second_moment,
//                                              gradient
//  out       source     out_valid / out_stall  new_param, new_first_moment,
//                                              new_second_moment, saturated
//  cfg       slave      psel/penable/pready    learning_rate at 0x0, step_count at 0x4
//
//  One transfer per cycle is taken on the input while in_stall is low. The pipeline has
//  five front stages, 16 square-root stages (two root bits each), one denominator stage,
//  38 divider stages (two quotient bits each), one write-back stage and the output queue.
//  Writing step_count starts the correction engine: one multiply per cycle while squaring
//  and multiplying, then one quotient bit per cycle; input is stalled meanwhile.
//  Reset is asynchronous; corrections come up at their step-one values, no sweep.
//  A two-entry output queue keeps taking input while one result waits on out_stall;
//  the whole pipeline freezes, losing nothing, only once the queue is full.
module adam_parameter_update_core (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] param_value,
    input  logic signed [31:0] first_moment,
    input  logic [30:0]        second_moment,
    input  logic signed [31:0] gradient,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_param,
    output logic signed [31:0] new_first_moment,
    output logic [30:0]        new_second_moment,
    output logic               saturated,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import apu_pkg::*;

    // register index as seen in paddr[2]
    localparam logic REG_LR   = 1'b0;
    localparam logic REG_STEP = 1'b1;

    logic [LR_W-1:0] lr_reg;
    logic [15:0]     step_reg;
    logic            cfg_wr;
    logic            step_wr;

    logic            corr_busy;
    logic [31:0]     c1_w, c2_w;

    logic            adv, accept;
    logic            fr_valid, sq_valid, dv_valid;
    item_t           fr_item, sq_item;
    logic [63:0]     fr_x;
    logic [NUM_W-1:0] fr_num, sq_num;
    logic [31:0]     sq_root;
    result_t         dv_res;

    // output queue
    result_t         q_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop, q_full;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign step_wr = cfg_wr && (paddr[2] == REG_STEP);
    assign prdata  = (paddr[2] == REG_STEP) ? {16'd0, step_reg} : {1'b0, lr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LR_W'(268435);
            step_reg <= 16'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_LR:   lr_reg   <= pwdata[LR_W-1:0];
                REG_STEP: step_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    apu_corr u_corr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (step_wr),
        .step  (pwdata[15:0]),
        .busy  (corr_busy),
        .c1    (c1_w),
        .c2    (c2_w)
    );

    // ---------------- flow control ----------------
    // pipeline moves as a whole whenever the output queue has room
    assign q_full   = (cnt_reg == 2'd2);
    assign adv      = !q_full;
    assign in_stall = q_full | corr_busy;
    assign accept   = in_valid & !in_stall;

    apu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .up_valid      (accept),
        .param_value   (param_value),
        .first_moment  (first_moment),
        .second_moment (second_moment),
        .gradient      (gradient),
        .lr            (lr_reg),
        .c1            (c1_w),
        .c2            (c2_w),
        .dn_valid      (fr_valid),
        .dn_item       (fr_item),
        .dn_x          (fr_x),
        .dn_num        (fr_num)
    );

    apu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .up_valid (fr_valid),
        .up_item  (fr_item),
        .up_x     (fr_x),
        .up_num   (fr_num),
        .dn_valid (sq_valid),
        .dn_item  (sq_item),
        .dn_num   (sq_num),
        .dn_root  (sq_root)
    );

    apu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .up_valid (sq_valid),
        .up_item  (sq_item),
        .up_num   (sq_num),
        .up_root  (sq_root),
        .dn_valid (dv_valid),
        .dn_res   (dv_res)
    );

    // ---------------- output queue ----------------
    assign push = adv & dv_valid;
    assign pop  = out_valid & !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dv_res;
    end

    assign out_valid         = (cnt_reg != 2'd0);
    assign new_param         = q_reg[rd_ptr_reg].new_param;
    assign new_first_moment  = q_reg[rd_ptr_reg].new_first_moment;
    assign new_second_moment = q_reg[rd_ptr_reg].new_second_moment;
    assign saturated         = q_reg[rd_ptr_reg].saturated;

    // ---------------- checks ----------------
    `APU_ASSERT_ALW(a_q_count, clk, rst_n, cnt_reg != 2'd3, "output queue count out of range")
    `APU_ASSERT_IMP(a_q_room, clk, rst_n, push, cnt_reg != 2'd2, "result pushed into full queue")
    `APU_ASSERT_NXT(a_step_hold, clk, rst_n, step_wr, in_stall, "input taken during update")
endmodule
`default_nettype wire
